// File: hw/rtl/twelve_bit_accumulator_execute_unit_assert.svh
// Assertion macros for the accumulator execute unit.
`ifndef TWELVE_BIT_ACCUMULATOR_EXECUTE_UNIT_ASSERT_SVH
`define TWELVE_BIT_ACCUMULATOR_EXECUTE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TBAE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TBAE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/tbae_pkg.sv
// Shared types and constants for the accumulator execute unit.
package tbae_pkg;

	localparam int WORD_W = 12;
	localparam int OP_W   = 5;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [OP_W-1:0] {
		OP_AND = 5'd0,
		OP_TAD = 5'd1,
		OP_ISZ = 5'd2,
		OP_DCA = 5'd3,
		OP_JMS = 5'd4,
		OP_JMP = 5'd5,
		OP_CLA = 5'd6,
		OP_CLL = 5'd7,
		OP_CMA = 5'd8,
		OP_CML = 5'd9,
		OP_IAC = 5'd10,
		OP_RAR = 5'd11,
		OP_RTR = 5'd12,
		OP_RAL = 5'd13,
		OP_RTL = 5'd14,
		OP_SMA = 5'd15,
		OP_SZA = 5'd16,
		OP_SNL = 5'd17,
		OP_SPA = 5'd18,
		OP_SNA = 5'd19,
		OP_SZL = 5'd20,
		OP_SKP = 5'd21,
		OP_OSR = 5'd22,
		OP_HLT = 5'd23
	} op_t;

	typedef struct packed {
		logic [OP_W-1:0] req_type;
		word_t           mem_data;
		word_t           eff_addr;
		word_t           current_pc;
		word_t           switch_reg;
	} req_t;

	typedef struct packed {
		word_t acc_out;
		logic  link_out;
		word_t next_pc;
		logic  write_enable;
		word_t write_data;
		logic  halted;
	} rsp_t;

endpackage

// File: hw/rtl/tbae_intf.sv
// Request and response channel interfaces for the accumulator execute unit.
interface tbae_req_if;
	logic                        valid;
	logic                        ready;
	logic [tbae_pkg::OP_W-1:0]   req_type;
	tbae_pkg::word_t             mem_data;
	tbae_pkg::word_t             eff_addr;
	tbae_pkg::word_t             current_pc;
	tbae_pkg::word_t             switch_reg;

	modport source (output valid, req_type, mem_data, eff_addr, current_pc, switch_reg,
		input ready);
	modport sink (input valid, req_type, mem_data, eff_addr, current_pc, switch_reg,
		output ready);
endinterface

interface tbae_rsp_if;
	logic            valid;
	logic            ready;
	tbae_pkg::word_t acc_out;
	logic            link_out;
	tbae_pkg::word_t next_pc;
	logic            write_enable;
	tbae_pkg::word_t write_data;
	logic            halted;

	modport source (output valid, acc_out, link_out, next_pc, write_enable, write_data,
		halted, input ready);
	modport sink (input valid, acc_out, link_out, next_pc, write_enable, write_data,
		halted, output ready);
endinterface

// File: hw/rtl/twelve_bit_accumulator_execute_unit.sv
// Execute stage of a 12-bit accumulator machine: accumulator, link, next PC, store request.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+--------------------------------------------------------
//  req     | in  | valid/ready  | req_type, mem_data, eff_addr, current_pc, switch_reg
//  rsp     | out | valid/ready  | acc_out, link_out, next_pc, write_enable, write_data,
//          |     |              | halted
//
// One request a cycle sustained while rsp.ready is high; rsp.valid rises once the request
// has passed the stage 1 and stage 2 registers, and the response handshake follows.
// Stage 1 registers the request; the execute logic between stage 1 and stage 2 is one
// 13-bit add, four 12-bit increments and rotate/logic selection on acc and link.
// Reset clears accumulator, link and both stage valids; no clearing pass is needed.
// A stalled rsp holds stage 2; stage 1 still fills, so req.ready drops only when both
// stages are full and rsp.ready is low.
`include "twelve_bit_accumulator_execute_unit_assert.svh"

module twelve_bit_accumulator_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	tbae_req_if.sink    req,
	tbae_rsp_if.source  rsp
);

	localparam int W = tbae_pkg::WORD_W;

	// Architectural state: only changes when an item moves from stage 1 to stage 2,
	// so the results stay in strict request order.
	tbae_pkg::word_t acc_q;
	logic            link_q;

	logic            valid_s1;
	tbae_pkg::req_t  req_s1;
	logic            valid_s2;
	tbae_pkg::rsp_t  rsp_s2;

	logic            adv_s1;     // stage 1 item executes and moves to stage 2
	logic            take_req;

	tbae_pkg::op_t   op;
	tbae_pkg::word_t acc_d;
	logic            link_d;
	logic            skip;
	logic [W:0]      tad_sum;
	tbae_pkg::word_t isz_val;
	tbae_pkg::word_t pc_inc;
	tbae_pkg::rsp_t  rsp_d;

	// Stage 2 is free when empty or being drained this cycle.
	assign adv_s1   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign take_req = req.valid && req.ready;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			req_s1.req_type   <= req.req_type;
			req_s1.mem_data   <= req.mem_data;
			req_s1.eff_addr   <= req.eff_addr;
			req_s1.current_pc <= req.current_pc;
			req_s1.switch_reg <= req.switch_reg;
		end
	end

	// ---------------------------------------------------------------- execute
	assign op      = tbae_pkg::op_t'(req_s1.req_type);
	assign tad_sum = {1'b0, acc_q} + {1'b0, req_s1.mem_data};
	assign isz_val = req_s1.mem_data + W'(1);
	assign pc_inc  = req_s1.current_pc + W'(1);

	always_comb begin
		acc_d  = acc_q;
		link_d = link_q;
		skip   = 1'b0;
		rsp_d  = '0;
		rsp_d.next_pc = req_s1.current_pc;
		unique case (op)
			tbae_pkg::OP_AND: begin
				acc_d = acc_q & req_s1.mem_data;
			end
			tbae_pkg::OP_TAD: begin
				// carry out of bit 11 flips the link rather than setting it
				acc_d  = tad_sum[W-1:0];
				link_d = link_q ^ tad_sum[W];
			end
			tbae_pkg::OP_ISZ: begin
				rsp_d.write_enable = 1'b1;
				rsp_d.write_data   = isz_val;
				skip               = (isz_val == '0);
			end
			tbae_pkg::OP_DCA: begin
				rsp_d.write_enable = 1'b1;
				rsp_d.write_data   = acc_q;
				acc_d              = '0;
			end
			tbae_pkg::OP_JMS: begin
				// return address stored at the target, execution resumes one past it
				rsp_d.write_enable = 1'b1;
				rsp_d.write_data   = req_s1.current_pc;
				rsp_d.next_pc      = req_s1.eff_addr + W'(1);
			end
			tbae_pkg::OP_JMP: begin
				rsp_d.next_pc = req_s1.eff_addr;
			end
			tbae_pkg::OP_CLA: begin
				acc_d = '0;
			end
			tbae_pkg::OP_CLL: begin
				link_d = 1'b0;
			end
			tbae_pkg::OP_CMA: begin
				acc_d = ~acc_q;
			end
			tbae_pkg::OP_CML: begin
				link_d = ~link_q;
			end
			tbae_pkg::OP_IAC: begin
				acc_d = acc_q + W'(1);
			end
			// rotates run over the 13-bit {link, acc} ring
			tbae_pkg::OP_RAR: begin
				acc_d  = {link_q, acc_q[W-1:1]};
				link_d = acc_q[0];
			end
			tbae_pkg::OP_RTR: begin
				acc_d  = {acc_q[0], link_q, acc_q[W-1:2]};
				link_d = acc_q[1];
			end
			tbae_pkg::OP_RAL: begin
				acc_d  = {acc_q[W-2:0], link_q};
				link_d = acc_q[W-1];
			end
			tbae_pkg::OP_RTL: begin
				acc_d  = {acc_q[W-3:0], link_q, acc_q[W-1]};
				link_d = acc_q[W-2];
			end
			tbae_pkg::OP_SMA: skip = acc_q[W-1];
			tbae_pkg::OP_SZA: skip = (acc_q == '0);
			tbae_pkg::OP_SNL: skip = link_q;
			tbae_pkg::OP_SPA: skip = !acc_q[W-1];
			tbae_pkg::OP_SNA: skip = (acc_q != '0);
			tbae_pkg::OP_SZL: skip = !link_q;
			tbae_pkg::OP_SKP: skip = 1'b1;
			tbae_pkg::OP_OSR: begin
				acc_d = acc_q | req_s1.switch_reg;
			end
			tbae_pkg::OP_HLT: begin
				rsp_d.halted = 1'b1;
			end
			default: begin
				// unassigned codes: acc, link and PC unchanged, no store requested
			end
		endcase
		if (skip) begin
			rsp_d.next_pc = pc_inc;
		end
		rsp_d.acc_out  = acc_d;
		rsp_d.link_out = link_d;
	end

	// ---------------------------------------------------------------- state and stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			link_q   <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				acc_q  <= acc_d;
				link_q <= link_d;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.acc_out      = rsp_s2.acc_out;
	assign rsp.link_out     = rsp_s2.link_out;
	assign rsp.next_pc      = rsp_s2.next_pc;
	assign rsp.write_enable = rsp_s2.write_enable;
	assign rsp.write_data   = rsp_s2.write_data;
	assign rsp.halted       = rsp_s2.halted;

	// ---------------------------------------------------------------- assertions
	`TBAE_ASSERT_NEXT(a_state_only_on_advance, clk, arst_n, !adv_s1, $stable(acc_q) && $stable(link_q), "accumulator or link changed without an executing request")
	`TBAE_ASSERT_NOW(a_no_overwrite_s1, clk, arst_n, take_req && valid_s1, adv_s1, "stage 1 overwritten before it executed")
	`TBAE_ASSERT_NOW(a_idle_write_data, clk, arst_n, valid_s2 && !rsp_s2.write_enable, rsp_s2.write_data == '0, "write data not zero without a store")
	`TBAE_ASSERT_NOW(a_halt_no_store, clk, arst_n, valid_s2 && rsp_s2.halted, !rsp_s2.write_enable, "halt raised together with a store request")

endmodule
